FILE: rtl/desa_pkg.sv
// ----------------------------------------------------------------------------
// desa_pkg: shared types and constants for the double-ended stack allocator
// Holds the request and response payload structs, the request codes and the
// fixed field widths used by the interfaces and the modules.
// ----------------------------------------------------------------------------
package desa_pkg;

  // Width of every offset, size and marker field on the ports
  localparam int FIELD_BITS = 16;
  localparam int ALIGN_BITS = 4;
  localparam int FUNC_BITS  = 2;

  // Working width for aligned sums: room for rounding up by a full
  // alignment mask and then adding a size, so nothing wraps
  localparam int SUM_BITS = FIELD_BITS + 2;

  // Request codes
  localparam logic [FUNC_BITS-1:0] FUNC_ALLOC_FRONT = 2'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_ALLOC_BACK  = 2'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_ROLLBACK    = 2'd2;
  localparam logic [FUNC_BITS-1:0] FUNC_RESET       = 2'd3;

  typedef struct packed {
    logic [FUNC_BITS-1:0]  func;
    logic [FIELD_BITS-1:0] size;
    logic [ALIGN_BITS-1:0] align_log2;
    logic [FIELD_BITS-1:0] mark_front;
    logic [FIELD_BITS-1:0] mark_back;
  } req_t;

  typedef struct packed {
    logic                  ok;
    logic [FIELD_BITS-1:0] offset;
    logic [FIELD_BITS-1:0] front_now;
    logic [FIELD_BITS-1:0] back_now;
  } rsp_t;

endpackage

FILE: rtl/desa_if.sv
// ----------------------------------------------------------------------------
// desa interfaces: request, response and configuration channels
// Each channel moves one beat when valid and ready are both high at a rising
// clock edge. The source drives valid and payload, the sink drives ready.
// ----------------------------------------------------------------------------
interface desa_req_if;
  logic                            valid;
  logic                            ready;
  logic [desa_pkg::FUNC_BITS-1:0]  func;
  logic [desa_pkg::FIELD_BITS-1:0] size;
  logic [desa_pkg::ALIGN_BITS-1:0] align_log2;
  logic [desa_pkg::FIELD_BITS-1:0] mark_front;
  logic [desa_pkg::FIELD_BITS-1:0] mark_back;

  modport source (output valid, func, size, align_log2, mark_front, mark_back,
                  input ready);
  modport sink   (input valid, func, size, align_log2, mark_front, mark_back,
                  output ready);
endinterface

interface desa_rsp_if;
  logic                            valid;
  logic                            ready;
  logic                            ok;
  logic [desa_pkg::FIELD_BITS-1:0] offset;
  logic [desa_pkg::FIELD_BITS-1:0] front_now;
  logic [desa_pkg::FIELD_BITS-1:0] back_now;

  modport source (output valid, ok, offset, front_now, back_now, input ready);
  modport sink   (input valid, ok, offset, front_now, back_now, output ready);
endinterface

interface desa_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [desa_pkg::FIELD_BITS-1:0] capacity;

  modport source (output valid, capacity, input ready);
  modport sink   (input valid, capacity, output ready);
endinterface

FILE: rtl/desa_step.sv
// ----------------------------------------------------------------------------
// desa_step: single-request update logic
// Works out the result and the next front and back offsets for one request
// from the current offsets and the configured capacity.
// ----------------------------------------------------------------------------
module desa_step #(
  parameter int OFF_W = 16
) (
  input  logic [OFF_W-1:0]     capacity,
  input  logic [OFF_W-1:0]     front_top,
  input  logic [OFF_W-1:0]     back_top,
  input  desa_pkg::req_t       req,
  output logic [OFF_W-1:0]     front_next,
  output logic [OFF_W-1:0]     back_next,
  output desa_pkg::rsp_t       rsp
);
  import desa_pkg::*;

  logic [SUM_BITS-1:0] amask;
  logic [SUM_BITS-1:0] size_x;
  logic [SUM_BITS-1:0] front_x;
  logic [SUM_BITS-1:0] back_x;
  logic [SUM_BITS-1:0] mf_x;
  logic [SUM_BITS-1:0] mb_x;
  logic [SUM_BITS-1:0] cap_x;
  logic [SUM_BITS-1:0] f_start;
  logic [SUM_BITS-1:0] f_end;
  logic [SUM_BITS-1:0] b_start;
  logic                size_nz;
  logic                f_ok;
  logic                b_ok;
  logic                r_ok;

  // Fields are taken modulo the offset width
  assign size_x  = SUM_BITS'(req.size[OFF_W-1:0]);
  assign mf_x    = SUM_BITS'(req.mark_front[OFF_W-1:0]);
  assign mb_x    = SUM_BITS'(req.mark_back[OFF_W-1:0]);
  assign front_x = SUM_BITS'(front_top);
  assign back_x  = SUM_BITS'(back_top);
  assign cap_x   = SUM_BITS'(capacity);
  assign amask   = (SUM_BITS'(1) << req.align_log2) - SUM_BITS'(1);
  assign size_nz = (size_x != '0);

  // Front: round the top up, then check the end against the back top
  assign f_start = (front_x + amask) & ~amask;
  assign f_end   = f_start + size_x;
  assign f_ok    = size_nz && (f_end <= back_x);

  // Back: refuse a size past the back top, then round the start down
  assign b_start = (back_x - size_x) & ~amask;
  assign b_ok    = size_nz && (size_x <= back_x) && (b_start >= front_x);

  // Rollback marker must be ordered and inside the buffer
  assign r_ok    = (mf_x <= mb_x) && (mb_x <= cap_x);

  always_comb begin
    front_next = front_top;
    back_next  = back_top;
    rsp.ok     = 1'b0;
    rsp.offset = '0;
    unique case (req.func)
      FUNC_ALLOC_FRONT: begin
        if (f_ok) begin
          front_next = OFF_W'(f_end);
          rsp.ok     = 1'b1;
          rsp.offset = FIELD_BITS'(f_start);
        end
      end
      FUNC_ALLOC_BACK: begin
        if (b_ok) begin
          back_next  = OFF_W'(b_start);
          rsp.ok     = 1'b1;
          rsp.offset = FIELD_BITS'(b_start);
        end
      end
      FUNC_ROLLBACK: begin
        if (r_ok) begin
          front_next = OFF_W'(mf_x);
          back_next  = OFF_W'(mb_x);
          rsp.ok     = 1'b1;
        end
      end
      FUNC_RESET: begin
        front_next = '0;
        back_next  = capacity;
        rsp.ok     = 1'b1;
      end
      default: begin
        front_next = front_top;
        back_next  = back_top;
      end
    endcase
    rsp.front_now = FIELD_BITS'(front_next);
    rsp.back_now  = FIELD_BITS'(back_next);
  end

endmodule

FILE: rtl/double_ended_stack_allocator_core.sv
// ----------------------------------------------------------------------------
// double_ended_stack_allocator_core: double-ended stack allocator
// Keeps a front offset growing up from zero and a back offset growing down
// from the configured capacity, and serves allocate, rollback and reset
// requests against them, one response beat per request beat.
//
//   channel  role    beat carries
//   -------  ------  ------------------------------------------------------
//   req      sink    func, size, align_log2, mark_front, mark_back
//   rsp      source  ok, offset, front_now, back_now
//   cfg      sink    capacity (also restarts the stack)
//
// Each request goes from its req beat into the input register, then through
// the update logic into the result register and out as its rsp beat. A new
// request is taken every cycle while rsp flows; the offsets update in place
// as a request leaves the input register, so back-to-back requests see each
// other's effects. rst clears both stages and loads capacity with all ones.
// A stalled rsp holds the result register; req stays ready while the input
// register is empty or about to move on. cfg is always ready.
// ----------------------------------------------------------------------------
module double_ended_stack_allocator_core #(
  parameter int OFFSET_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  desa_req_if.sink   req,
  desa_rsp_if.source rsp,
  desa_cfg_if.sink   cfg
);
  import desa_pkg::*;

  // Offsets never exceed the port width, so keep no more bits than that
  localparam int OFF_W = (OFFSET_BITS < FIELD_BITS) ? OFFSET_BITS : FIELD_BITS;

  logic [OFF_W-1:0] capacity;
  logic [OFF_W-1:0] front_top;
  logic [OFF_W-1:0] back_top;
  logic [OFF_W-1:0] front_next;
  logic [OFF_W-1:0] back_next;

  logic             in_valid;
  req_t             in_req;
  logic             out_valid;
  rsp_t             out_rsp;
  rsp_t             step_rsp;
  req_t             req_beat;

  logic             advance;
  logic             req_take;

  // Result register frees up when empty or when its beat goes out
  assign advance  = !out_valid || rsp.ready;
  assign req.ready = !in_valid || advance;
  assign req_take = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  assign req_beat.func       = req.func;
  assign req_beat.size       = req.size;
  assign req_beat.align_log2 = req.align_log2;
  assign req_beat.mark_front = req.mark_front;
  assign req_beat.mark_back  = req.mark_back;

  desa_step #(
    .OFF_W (OFF_W)
  ) u_step (
    .capacity   (capacity),
    .front_top  (front_top),
    .back_top   (back_top),
    .req        (in_req),
    .front_next (front_next),
    .back_next  (back_next),
    .rsp        (step_rsp)
  );

  // Input register: load on every accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
    if (req_take) begin
      in_req <= req_beat;
    end
  end

  // Offsets and capacity: a capacity write restarts the stack
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= '1;
      front_top <= '0;
      back_top  <= '1;
    end else if (cfg.valid) begin
      capacity  <= cfg.capacity[OFF_W-1:0];
      front_top <= '0;
      back_top  <= cfg.capacity[OFF_W-1:0];
    end else if (in_valid && advance) begin
      front_top <= front_next;
      back_top  <= back_next;
    end
  end

  // Result register: hold while the sink stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
    if (advance && in_valid) begin
      out_rsp <= step_rsp;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.ok        = out_rsp.ok;
  assign rsp.offset    = out_rsp.offset;
  assign rsp.front_now = out_rsp.front_now;
  assign rsp.back_now  = out_rsp.back_now;

endmodule
